[sv/crc32ta_pkg.sv]
// Shared types, constants and the byte-wise CRC-32 update for the trailer appender.
`timescale 1ns / 1ps
`default_nettype none

package crc32ta_pkg;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned CRC_W         = 32;
    localparam int unsigned TRAILER_BYTES = CRC_W / BYTE_W;
    localparam int unsigned TRAIL_CNT_W   = $clog2(TRAILER_BYTES + 1);

    localparam logic [CRC_W-1:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_PRESET = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } item_t;

    // Reflected CRC-32 update of one byte, one shift-and-reduce per bit.
    function automatic logic [CRC_W-1:0] crc_fold_byte(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] v;
        v = {{(CRC_W-BYTE_W){1'b0}}, crc[BYTE_W-1:0] ^ data};
        for (int k = 0; k < BYTE_W; k++)
        begin
            v = (v >> 1) ^ (v[0] ? CRC_POLY : '0);
        end
        return (crc >> BYTE_W) ^ v;
    endfunction

endpackage

`default_nettype wire

[sv/crc32ta_core.sv]
// CRC register, byte pass-through and trailer sequencer of the trailer appender.
`timescale 1ns / 1ps
`default_nettype none

module crc32ta_core
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [crc32ta_pkg::BYTE_W-1:0]      in_data,
    input  wire logic                                in_last,
    output logic                                     emit_valid,
    input  wire logic                                emit_ready,
    output crc32ta_pkg::item_t                       emit_item
);

    logic [crc32ta_pkg::CRC_W-1:0]       crc_reg;
    logic [crc32ta_pkg::CRC_W-1:0]       crc_next;
    logic [crc32ta_pkg::CRC_W-1:0]       trailer_reg;
    logic [crc32ta_pkg::TRAIL_CNT_W-1:0] trail_cnt_reg;
    logic                                trailing;
    logic                                in_fire;

    assign trailing = (trail_cnt_reg != '0);
    assign in_ready = !trailing && emit_ready;
    assign in_fire  = in_valid && in_ready;
    assign crc_next = crc32ta_pkg::crc_fold_byte(crc_reg, in_data);

    always_comb
    begin
        if (trailing)
        begin
            emit_valid     = 1'b1;
            emit_item.data = trailer_reg[crc32ta_pkg::BYTE_W-1:0];
            emit_item.last = (trail_cnt_reg == crc32ta_pkg::TRAIL_CNT_W'(1));
        end
        else
        begin
            emit_valid     = in_valid;
            emit_item.data = in_data;
            emit_item.last = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= crc32ta_pkg::CRC_PRESET;
            trail_cnt_reg <= '0;
        end
        else if (trailing)
        begin
            if (emit_ready)
            begin
                trail_cnt_reg <= trail_cnt_reg - crc32ta_pkg::TRAIL_CNT_W'(1);
            end
        end
        else if (in_fire)
        begin
            if (in_last)
            begin
                crc_reg       <= crc32ta_pkg::CRC_PRESET;
                trail_cnt_reg <= crc32ta_pkg::TRAIL_CNT_W'(crc32ta_pkg::TRAILER_BYTES);
            end
            else
            begin
                crc_reg <= crc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && in_last)
        begin
            trailer_reg <= crc_next;
        end
        else if (trailing && emit_ready)
        begin
            trailer_reg <= trailer_reg >> crc32ta_pkg::BYTE_W;
        end
    end

    a_no_request_while_trailing: assert property (@(posedge clk) disable iff (!rst_n)
        trailing |-> !in_ready)
        else $error("Input request taken while the trailer is being sent.");

    a_last_starts_trailer: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_last) |=>
            (trail_cnt_reg == crc32ta_pkg::TRAIL_CNT_W'(crc32ta_pkg::TRAILER_BYTES)))
        else $error("Trailer did not start after the last byte.");

    a_preset_during_trailer: assert property (@(posedge clk) disable iff (!rst_n)
        trailing |-> (crc_reg == crc32ta_pkg::CRC_PRESET))
        else $error("CRC register not preset while the trailer is sent.");

endmodule

`default_nettype wire

[sv/crc32ta_out_buf.sv]
// Two-entry output register with skid stage for the trailer appender.
`timescale 1ns / 1ps
`default_nettype none

module crc32ta_out_buf
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push_valid,
    output logic                                    push_ready,
    input  wire crc32ta_pkg::item_t                 push_item,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output crc32ta_pkg::item_t                      out_item
);

    logic               out_valid_reg;
    logic               skid_valid_reg;
    crc32ta_pkg::item_t out_item_reg;
    crc32ta_pkg::item_t skid_item_reg;
    logic               push_fire;
    logic               out_free;

    assign push_ready = !skid_valid_reg;
    assign push_fire  = push_valid && push_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign out_item   = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push_fire;
            end
        end
        else if (push_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_item_reg <= skid_item_reg;
            end
            else if (push_fire)
            begin
                out_item_reg <= push_item;
            end
        end
        else if (push_fire)
        begin
            skid_item_reg <= push_item;
        end
    end

    a_skid_behind_output: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid entry held while the output register is empty.");

endmodule

`default_nettype wire

[sv/crc32_trailer_appender.sv]
// Top level: passes bytes through and appends a four-byte reflected CRC-32 trailer without final XOR.
// An accepted byte is registered in the output entry, or in the skid entry while the output stalls.
// Throughput: one byte per cycle unless held off; a request marked last is followed by four trailer
// bytes, so an image of N bytes leaves as N + 4 output bytes on the single output port.
// Input is held off only while the trailer is sent or the skid stage is full.
// Reset: the CRC register is preset to all ones and both output entries are emptied.
`timescale 1ns / 1ps
`default_nettype none

module crc32_trailer_appender
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  wire logic       s_axis_tlast,   // last_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast    // out_last
);

    logic               emit_valid;
    logic               emit_ready;
    crc32ta_pkg::item_t emit_item;
    crc32ta_pkg::item_t out_item;

    crc32ta_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .emit_valid (emit_valid),
        .emit_ready (emit_ready),
        .emit_item  (emit_item)
    );

    crc32ta_out_buf u_out_buf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (emit_valid),
        .push_ready (emit_ready),
        .push_item  (emit_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_item   (out_item)
    );

    assign m_axis_tdata = out_item.data;
    assign m_axis_tlast = out_item.last;

endmodule

`default_nettype wire
